[rtl/lsng_pkg.sv]
package lsng_pkg;

	localparam int MAX_NEIGHBORS_DEF = 32;
	localparam int NUM_FUNCS_DEF     = 5;
	localparam int IN_W              = 32;
	localparam int VAL_W             = 64;
	localparam int GRAD_W            = 48;
	localparam int FIDX_W            = 3;
	localparam int MAX_DIFFS         = 5;
	localparam int NUM_COEF          = 8;
	localparam int NUM_AXES          = 3;
	localparam int SH_W              = 6;
	localparam int STEP_W            = 3;

	typedef logic signed [VAL_W-1:0] val_t;

	localparam val_t SMAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam val_t G48MAX   = 64'sh0000_7FFF_FFFF_FFFF;
	localparam val_t G48MIN   = -64'sh0000_8000_0000_0000;

	// coefficient register slots
	localparam int C_R11  = 0;
	localparam int C_R12  = 1;
	localparam int C_R13  = 2;
	localparam int C_R22  = 3;
	localparam int C_R23  = 4;
	localparam int C_RO22 = 5;
	localparam int C_R33  = 6;
	localparam int C_RO33 = 7;

	// fixed point shifts
	localparam logic [SH_W-1:0] SH_NONE  = 6'd0;
	localparam logic [SH_W-1:0] SH_UNIT  = 6'd16;
	localparam logic [SH_W-1:0] SH_RATIO = 6'd32;
	localparam logic [SH_W-1:0] SH_WGT   = 6'd48;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_LD, S_SQ, S_RT, S_SC, S_WB, S_ACC,
		S_Q2, S_Q3, S_WGT, S_GRD, S_NEXT, S_PEND, S_DIVS, S_EMIT
	} state_t;

	typedef enum logic [1:0] {PASS_R1, PASS_R2, PASS_R3, PASS_W} pass_t;

	typedef enum logic [1:0] {U_NONE, U_MUL, U_DIV, U_SQRT} unit_t;

	typedef struct packed {
		val_t             a;
		val_t             b;
		logic [SH_W-1:0]  k;
	} op_req_t;

	function automatic logic [VAL_W-1:0] mag(input val_t x);
		return x[VAL_W-1] ? VAL_W'(-x) : VAL_W'(x);
	endfunction

	function automatic val_t sat_mag(input logic neg, input logic [VAL_W-1:0] m);
		logic [VAL_W-1:0] mm;
		mm = (m > 64'h7FFF_FFFF_FFFF_FFFF) ? 64'h7FFF_FFFF_FFFF_FFFF : m;
		return neg ? -val_t'(mm) : val_t'(mm);
	endfunction

	function automatic val_t sadd(input val_t a, input val_t b);
		logic signed [VAL_W:0] s;
		s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF)
			return SMAX;
		else if (s < -65'sh0_7FFF_FFFF_FFFF_FFFF)
			return -SMAX;
		return s[VAL_W-1:0];
	endfunction

	function automatic val_t ssub(input val_t a, input val_t b);
		return sadd(a, -b);
	endfunction

	function automatic logic [GRAD_W-1:0] clamp48(input val_t v);
		val_t c;
		c = v;
		if (v > G48MAX)
			c = G48MAX;
		else if (v < G48MIN)
			c = G48MIN;
		return c[GRAD_W-1:0];
	endfunction

endpackage

[rtl/lsng_mul.sv]
module lsng_mul (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  lsng_pkg::op_req_t req,
	output logic             done,
	output lsng_pkg::val_t   res
);

	// (a*b)>>k on magnitudes: four 32x32 partial products, one per cycle
	logic [63:0]                    x_q, y_q;
	logic                           neg_q;
	logic [lsng_pkg::SH_W-1:0]      k_q;
	logic [63:0]                    pp_q;
	logic [127:0]                   acc_q;
	logic [lsng_pkg::STEP_W-1:0]    step_q;
	logic                           busy_q, done_q;
	lsng_pkg::val_t                 res_q;

	logic [31:0]  xs, ys;
	logic [127:0] pp_sh, r;
	logic [63:0]  rlo;

	always_comb begin
		xs = step_q[1] ? x_q[63:32] : x_q[31:0];
		ys = step_q[0] ? y_q[63:32] : y_q[31:0];
		unique case (step_q)
			3'd1:    pp_sh = {64'd0, pp_q};
			3'd2,
			3'd3:    pp_sh = {32'd0, pp_q, 32'd0};
			3'd4:    pp_sh = {pp_q, 64'd0};
			default: pp_sh = '0;
		endcase
		r   = acc_q >> k_q;
		rlo = (r[127:64] != '0) ? '1 : r[63:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= !start && busy_q && (step_q == 3'd5);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == 3'd5)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= lsng_pkg::mag(req.a);
			y_q   <= lsng_pkg::mag(req.b);
			neg_q <= req.a[63] ^ req.b[63];
			k_q   <= req.k;
			acc_q <= '0;
		end else if (busy_q) begin
			if (step_q <= 3'd3)
				pp_q <= xs * ys;
			if (step_q >= 3'd1 && step_q <= 3'd4)
				acc_q <= acc_q + pp_sh;
			if (step_q == 3'd5)
				res_q <= lsng_pkg::sat_mag(neg_q, rlo);
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[rtl/lsng_div.sv]
module lsng_div (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  lsng_pkg::op_req_t req,
	output logic             done,
	output lsng_pkg::val_t   res
);

	// (a<<k)/b on magnitudes, restoring, one quotient bit per cycle
	logic [63:0]  rem_q, lo_q, q_q, d_q;
	logic         neg_q;
	logic [5:0]   cnt_q;
	logic         busy_q, done_q;
	lsng_pkg::val_t res_q;

	logic [63:0]  xm, dm;
	logic [127:0] num;
	logic [64:0]  rem2, diff;
	logic         ge;

	always_comb begin
		xm   = lsng_pkg::mag(req.a);
		dm   = lsng_pkg::mag(req.b);
		num  = {64'd0, xm} << req.k;
		rem2 = {rem_q, lo_q[63]};
		diff = rem2 - {1'b0, d_q};
		ge   = rem2 >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= start ? (dm == '0 || num[127:64] >= dm)
				: (busy_q && cnt_q == 6'd63);
			if (start) begin
				cnt_q <= '0;
				if (!(dm == '0 || num[127:64] >= dm))
					busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == 6'd63)
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= req.a[63] ^ req.b[63];
			d_q   <= dm;
			rem_q <= num[127:64];
			lo_q  <= num[63:0];
			q_q   <= '0;
			if (dm == '0)
				res_q <= '0;
			else if (num[127:64] >= dm)
				res_q <= lsng_pkg::sat_mag(req.a[63] ^ req.b[63], '1);
		end else if (busy_q) begin
			rem_q <= ge ? diff[63:0] : rem2[63:0];
			lo_q  <= {lo_q[62:0], 1'b0};
			q_q   <= {q_q[62:0], ge};
			if (cnt_q == 6'd63)
				res_q <= lsng_pkg::sat_mag(neg_q, {q_q[62:0], ge});
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[rtl/lsng_sqrt.sv]
module lsng_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] x,
	output logic        done,
	output logic [63:0] res
);

	// digit-by-digit root, two radicand bits per cycle
	logic [63:0] x_q, r_q, bit_q;
	logic        busy_q, done_q;
	logic [63:0] rb, r_nx;
	logic        ge;

	always_comb begin
		rb   = r_q + bit_q;
		ge   = x_q >= rb;
		r_nx = ge ? ((r_q >> 1) + bit_q) : (r_q >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= !start && busy_q && bit_q[0];
			if (start)
				busy_q <= 1'b1;
			else if (busy_q && bit_q[0])
				busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			r_q   <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (busy_q) begin
			if (ge)
				x_q <= x_q - rb;
			r_q   <= r_nx;
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign res  = r_q;

endmodule

[rtl/lsng_store.sv]
module lsng_store #(
	parameter int MAX_NEIGHBORS = lsng_pkg::MAX_NEIGHBORS_DEF,
	parameter int NUM_FUNCS     = lsng_pkg::NUM_FUNCS_DEF
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [$clog2(MAX_NEIGHBORS)-1:0]             waddr,
	input  logic [(3+NUM_FUNCS)*lsng_pkg::VAL_W-1:0]     wdata,
	input  logic                                         re,
	input  logic [$clog2(MAX_NEIGHBORS)-1:0]             raddr,
	output logic [(3+NUM_FUNCS)*lsng_pkg::VAL_W-1:0]     rdata
);

	// one row per neighbor: offsets (or scaled offsets), then differences
	localparam int EW = (3 + NUM_FUNCS) * lsng_pkg::VAL_W;

	logic [EW-1:0] mem [MAX_NEIGHBORS];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

[rtl/least_squares_node_gradient.sv]
// Least-squares nodal gradient (Gram-Schmidt), fixed point.
// Input channel (in_valid/in_ready): one word per neighbor of a node, with
// offset_x/y/z and diff_0..4; last_neighbor closes the node. Words after
// MAX_NEIGHBORS are dropped, but a dropped last word still starts the solve.
// Output channel (out_valid/out_ready): NUM_FUNCS words per node, func_index
// counting up, last_result on the final one; degenerate = 1 with zero
// gradients if a pivot is zero. cfg_we/cfg_wdata write weight_mode
// (0 unweighted, 1 inverse distance); write only while idle.
// Neighbor words are taken back to back while the block is idle. After the
// last word the block solves over four passes of the neighbor memory and
// takes no input. Multiplies run on one shared 32x32 multiplier, divides on
// a bit-serial divider and roots on a digit-by-digit root unit.
// The result register lets the next node's neighbors enter while the final
// gradient word waits; a stalled receiver holds the output word and, before
// that, keeps the block from loading the word of the next function.
// Reset clears the neighbor count, weight_mode and the output valid.
module least_squares_node_gradient #(
	parameter int MAX_NEIGHBORS = lsng_pkg::MAX_NEIGHBORS_DEF,
	parameter int NUM_FUNCS     = lsng_pkg::NUM_FUNCS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [31:0]   offset_x,
	input  logic signed [31:0]   offset_y,
	input  logic signed [31:0]   offset_z,
	input  logic signed [31:0]   diff_0,
	input  logic signed [31:0]   diff_1,
	input  logic signed [31:0]   diff_2,
	input  logic signed [31:0]   diff_3,
	input  logic signed [31:0]   diff_4,
	input  logic                 last_neighbor,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [2:0]           func_index,
	output logic signed [47:0]   grad_x,
	output logic signed [47:0]   grad_y,
	output logic signed [47:0]   grad_z,
	output logic                 degenerate,
	output logic                 last_result
);

	localparam int AW    = $clog2(MAX_NEIGHBORS);
	localparam int CW    = $clog2(MAX_NEIGHBORS + 1);
	localparam int LANES = 3 + NUM_FUNCS;
	localparam int VIW   = $clog2(LANES);
	localparam int FIW   = (NUM_FUNCS > 1) ? $clog2(NUM_FUNCS) : 1;
	localparam int VW    = lsng_pkg::VAL_W;
	localparam int EW    = LANES * VW;

	// control
	lsng_pkg::state_t            state_q, state_d;
	lsng_pkg::pass_t             pass_q;
	logic [CW-1:0]               cnt_q, ncnt_q;
	logic [AW-1:0]               n_q;
	logic [lsng_pkg::STEP_W-1:0] j_q;
	logic [lsng_pkg::FIDX_W-1:0] f_q;
	logic [1:0]                  a_q;
	logic                        run_q, weight_mode_q, degen_q, out_valid_q;

	// datapath
	lsng_pkg::val_t v_q [LANES];
	lsng_pkg::val_t c_q [lsng_pkg::NUM_COEF];
	lsng_pkg::val_t g_q [NUM_FUNCS][lsng_pkg::NUM_AXES];
	lsng_pkg::val_t c12_q, c13_q, c23_q, q2_q, q3_q, wx_q, wy_q, wz_q, t_q;
	logic [63:0]    d2_q, len_q;

	// result register
	logic [lsng_pkg::FIDX_W-1:0] fidx_q;
	logic [lsng_pkg::GRAD_W-1:0] gx_q, gy_q, gz_q;
	logic                        dg_q, lr_q;

	// unit handshake
	lsng_pkg::unit_t   unit;
	lsng_pkg::op_req_t req;
	logic              unit_start, unit_done;
	logic              mul_done, div_done, sqrt_done;
	lsng_pkg::val_t    mul_res, div_res, ures;
	logic [63:0]       sqrt_res;

	logic              in_acc, start_node, room, last_n, last_acc, emit_ld, last_f;
	logic [VIW-1:0]    vidx;
	lsng_pkg::val_t    vsel, wsel;
	logic [2:0]        ci;

	// memory ports
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr;
	logic [EW-1:0]     mem_wdata, mem_rdata;
	logic signed [31:0] diff_in [lsng_pkg::MAX_DIFFS];

	assign in_ready   = (state_q == lsng_pkg::S_IDLE);
	assign in_acc     = in_valid && in_ready;
	assign start_node = in_acc && last_neighbor;
	assign room       = cnt_q < CW'(MAX_NEIGHBORS);
	assign last_n     = (CW'(n_q) + 1'b1) == ncnt_q;
	assign last_acc   = (pass_q == lsng_pkg::PASS_R3) ? (j_q == 3'd1) : (j_q == 3'd2);
	assign emit_ld    = (state_q == lsng_pkg::S_EMIT) && (!out_valid_q || out_ready);
	assign last_f     = f_q == lsng_pkg::FIDX_W'(NUM_FUNCS - 1);

	always_comb begin
		diff_in[0] = diff_0;
		diff_in[1] = diff_1;
		diff_in[2] = diff_2;
		diff_in[3] = diff_3;
		diff_in[4] = diff_4;
	end

	// write port: incoming neighbor, or scaled row written back in pass one
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = cnt_q[AW-1:0];
		mem_wdata = '0;
		if (state_q == lsng_pkg::S_WB) begin
			mem_we    = 1'b1;
			mem_waddr = n_q;
			for (int i = 0; i < LANES; i++)
				mem_wdata[i*VW +: VW] = v_q[i];
		end else begin
			mem_we = in_acc && room;
			mem_wdata[0*VW +: VW] = VW'(offset_x);
			mem_wdata[1*VW +: VW] = VW'(offset_y);
			mem_wdata[2*VW +: VW] = VW'(offset_z);
			for (int f = 0; f < NUM_FUNCS; f++)
				mem_wdata[(3+f)*VW +: VW] = VW'(diff_in[f]);
		end
		mem_re = (state_q == lsng_pkg::S_RD);
	end

	lsng_store #(
		.MAX_NEIGHBORS(MAX_NEIGHBORS),
		.NUM_FUNCS    (NUM_FUNCS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (n_q),
		.rdata (mem_rdata)
	);

	// operand selection for the shared arithmetic units
	always_comb begin
		vidx = j_q[VIW-1:0];
		if (state_q == lsng_pkg::S_GRD)
			vidx = VIW'(f_q) + VIW'(3);
		vsel = v_q[vidx];
		unique case (a_q)
			2'd0:    wsel = wx_q;
			2'd1:    wsel = wy_q;
			default: wsel = wz_q;
		endcase
		unique case (pass_q)
			lsng_pkg::PASS_R1: ci = j_q;
			lsng_pkg::PASS_R2: ci = j_q + 3'd3;
			default:           ci = j_q + 3'd6;
		endcase
	end

	always_comb begin
		unit  = lsng_pkg::U_NONE;
		req.a = '0;
		req.b = '0;
		req.k = lsng_pkg::SH_NONE;
		unique case (state_q)
			lsng_pkg::S_SQ: begin
				unit  = lsng_pkg::U_MUL;
				req.a = vsel;
				req.b = vsel;
			end
			lsng_pkg::S_RT: unit = lsng_pkg::U_SQRT;
			lsng_pkg::S_SC: begin
				unit  = lsng_pkg::U_DIV;
				req.a = vsel;
				req.b = lsng_pkg::val_t'(len_q);
				req.k = lsng_pkg::SH_UNIT;
			end
			lsng_pkg::S_ACC: begin
				unit = lsng_pkg::U_MUL;
				unique case (pass_q)
					lsng_pkg::PASS_R1: begin
						req.a = v_q[0];
						req.b = vsel;
					end
					lsng_pkg::PASS_R2: begin
						req.a = q2_q;
						req.b = (j_q == 3'd0) ? q2_q : (j_q == 3'd1) ? v_q[2] : v_q[1];
					end
					default: begin
						req.a = q3_q;
						req.b = (j_q == 3'd0) ? q3_q : v_q[2];
					end
				endcase
			end
			lsng_pkg::S_Q2: begin
				unit  = lsng_pkg::U_MUL;
				req.a = c12_q;
				req.b = v_q[0];
				req.k = lsng_pkg::SH_RATIO;
			end
			lsng_pkg::S_Q3: begin
				unit  = lsng_pkg::U_MUL;
				req.a = (j_q == 3'd0) ? c13_q : c23_q;
				req.b = (j_q == 3'd0) ? v_q[0] : q2_q;
				req.k = lsng_pkg::SH_RATIO;
			end
			lsng_pkg::S_WGT: begin
				req.k = lsng_pkg::SH_WGT;
				unique case (j_q)
					3'd0: begin
						unit = lsng_pkg::U_DIV;  req.a = q3_q;
						req.b = c_q[lsng_pkg::C_RO33];
					end
					3'd1: begin
						unit = lsng_pkg::U_MUL;  req.a = c_q[lsng_pkg::C_R23];
						req.b = wz_q;
					end
					3'd2: begin
						unit = lsng_pkg::U_DIV;  req.a = t_q;
						req.b = c_q[lsng_pkg::C_RO22];
					end
					3'd3: begin
						unit = lsng_pkg::U_MUL;  req.a = c_q[lsng_pkg::C_R12];
						req.b = wy_q;
					end
					3'd4: begin
						unit = lsng_pkg::U_MUL;  req.a = c_q[lsng_pkg::C_R13];
						req.b = wz_q;
					end
					default: begin
						unit = lsng_pkg::U_DIV;  req.a = t_q;
						req.b = c_q[lsng_pkg::C_R11];
					end
				endcase
			end
			lsng_pkg::S_GRD: begin
				unit  = lsng_pkg::U_MUL;
				req.a = wsel;
				req.b = vsel;
				req.k = lsng_pkg::SH_RATIO;
			end
			lsng_pkg::S_DIVS: begin
				unit  = lsng_pkg::U_DIV;
				req.k = lsng_pkg::SH_RATIO;
				if (pass_q == lsng_pkg::PASS_R1) begin
					req.a = (j_q == 3'd0) ? c_q[lsng_pkg::C_R12] : c_q[lsng_pkg::C_R13];
					req.b = c_q[lsng_pkg::C_R11];
				end else begin
					req.a = c_q[lsng_pkg::C_R23];
					req.b = c_q[lsng_pkg::C_R22];
				end
			end
			default: ;
		endcase
	end

	assign unit_start = (unit != lsng_pkg::U_NONE) && !run_q;

	always_comb begin
		unique case (unit)
			lsng_pkg::U_MUL:  unit_done = run_q && mul_done;
			lsng_pkg::U_DIV:  unit_done = run_q && div_done;
			lsng_pkg::U_SQRT: unit_done = run_q && sqrt_done;
			default:          unit_done = 1'b0;
		endcase
		ures = (unit == lsng_pkg::U_DIV) ? div_res : mul_res;
	end

	lsng_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (unit_start && unit == lsng_pkg::U_MUL),
		.req    (req),
		.done   (mul_done),
		.res    (mul_res)
	);

	lsng_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (unit_start && unit == lsng_pkg::U_DIV),
		.req    (req),
		.done   (div_done),
		.res    (div_res)
	);

	lsng_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (unit_start && unit == lsng_pkg::U_SQRT),
		.x      (d2_q),
		.done   (sqrt_done),
		.res    (sqrt_res)
	);

	// sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lsng_pkg::S_IDLE: if (start_node) state_d = lsng_pkg::S_RD;
			lsng_pkg::S_RD:   state_d = lsng_pkg::S_LD;
			lsng_pkg::S_LD: begin
				if (pass_q != lsng_pkg::PASS_R1)
					state_d = lsng_pkg::S_Q2;
				else
					state_d = weight_mode_q ? lsng_pkg::S_SQ : lsng_pkg::S_ACC;
			end
			lsng_pkg::S_SQ:
				if (unit_done && j_q == 3'd2) state_d = lsng_pkg::S_RT;
			lsng_pkg::S_RT:
				if (unit_done)
					state_d = (sqrt_res == '0) ? lsng_pkg::S_WB : lsng_pkg::S_SC;
			lsng_pkg::S_SC:
				if (unit_done && j_q == lsng_pkg::STEP_W'(LANES - 1))
					state_d = lsng_pkg::S_WB;
			lsng_pkg::S_WB:   state_d = lsng_pkg::S_ACC;
			lsng_pkg::S_ACC:
				if (unit_done && last_acc) state_d = lsng_pkg::S_NEXT;
			lsng_pkg::S_Q2:
				if (unit_done)
					state_d = (pass_q == lsng_pkg::PASS_R2) ? lsng_pkg::S_ACC : lsng_pkg::S_Q3;
			lsng_pkg::S_Q3:
				if (unit_done && j_q == 3'd1)
					state_d = (pass_q == lsng_pkg::PASS_R3) ? lsng_pkg::S_ACC : lsng_pkg::S_WGT;
			lsng_pkg::S_WGT:
				if (unit_done && j_q == 3'd5) state_d = lsng_pkg::S_GRD;
			lsng_pkg::S_GRD:
				if (unit_done && last_f && a_q == 2'd2) state_d = lsng_pkg::S_NEXT;
			lsng_pkg::S_NEXT: state_d = last_n ? lsng_pkg::S_PEND : lsng_pkg::S_RD;
			lsng_pkg::S_PEND: begin
				unique case (pass_q)
					lsng_pkg::PASS_R1:
						state_d = (c_q[lsng_pkg::C_R11] == '0) ? lsng_pkg::S_EMIT
							: lsng_pkg::S_DIVS;
					lsng_pkg::PASS_R2:
						state_d = (c_q[lsng_pkg::C_R22] == '0 || c_q[lsng_pkg::C_RO22] == '0)
							? lsng_pkg::S_EMIT : lsng_pkg::S_DIVS;
					lsng_pkg::PASS_R3:
						state_d = (c_q[lsng_pkg::C_RO33] == '0) ? lsng_pkg::S_EMIT
							: lsng_pkg::S_RD;
					default: state_d = lsng_pkg::S_EMIT;
				endcase
			end
			lsng_pkg::S_DIVS:
				if (unit_done && (pass_q != lsng_pkg::PASS_R1 || j_q == 3'd1))
					state_d = lsng_pkg::S_RD;
			lsng_pkg::S_EMIT:
				if (emit_ld && last_f) state_d = lsng_pkg::S_IDLE;
			default: state_d = lsng_pkg::S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= lsng_pkg::S_IDLE;
			pass_q        <= lsng_pkg::PASS_R1;
			cnt_q         <= '0;
			ncnt_q        <= '0;
			n_q           <= '0;
			j_q           <= '0;
			f_q           <= '0;
			a_q           <= '0;
			run_q         <= 1'b0;
			weight_mode_q <= 1'b0;
			degen_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				weight_mode_q <= cfg_wdata;

			if (unit_start)
				run_q <= 1'b1;
			else if (unit_done)
				run_q <= 1'b0;

			// step counters restart on every state change
			if (state_d != state_q) begin
				j_q <= '0;
				a_q <= '0;
				if (state_q != lsng_pkg::S_EMIT)
					f_q <= '0;
			end else if (unit_done) begin
				j_q <= j_q + 1'b1;
				if (state_q == lsng_pkg::S_GRD) begin
					if (a_q == 2'd2) begin
						a_q <= '0;
						f_q <= f_q + 1'b1;
					end else begin
						a_q <= a_q + 1'b1;
					end
				end
			end
			if (emit_ld)
				f_q <= last_f ? '0 : f_q + 1'b1;

			if (in_acc) begin
				if (last_neighbor) begin
					cnt_q  <= '0;
					ncnt_q <= room ? cnt_q + 1'b1 : cnt_q;
					n_q    <= '0;
					pass_q <= lsng_pkg::PASS_R1;
					degen_q <= 1'b0;
				end else if (room) begin
					cnt_q <= cnt_q + 1'b1;
				end
			end

			if (state_q == lsng_pkg::S_NEXT && !last_n)
				n_q <= n_q + 1'b1;
			if (state_q == lsng_pkg::S_PEND) begin
				n_q <= '0;
				if (state_d == lsng_pkg::S_EMIT && pass_q != lsng_pkg::PASS_W)
					degen_q <= 1'b1;
				if (pass_q == lsng_pkg::PASS_R3)
					pass_q <= lsng_pkg::PASS_W;
			end
			if (state_q == lsng_pkg::S_DIVS && state_d == lsng_pkg::S_RD)
				pass_q <= (pass_q == lsng_pkg::PASS_R1) ? lsng_pkg::PASS_R2
					: lsng_pkg::PASS_R3;

			if (emit_ld)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			lsng_pkg::S_IDLE:
				if (start_node) begin
					for (int i = 0; i < lsng_pkg::NUM_COEF; i++)
						c_q[i] <= '0;
					for (int f = 0; f < NUM_FUNCS; f++)
						for (int x = 0; x < lsng_pkg::NUM_AXES; x++)
							g_q[f][x] <= '0;
				end
			lsng_pkg::S_LD: begin
				for (int i = 0; i < LANES; i++)
					v_q[i] <= mem_rdata[i*VW +: VW];
				d2_q <= '0;
			end
			lsng_pkg::S_SQ:
				if (unit_done) d2_q <= d2_q + 64'(mul_res);
			lsng_pkg::S_RT:
				if (unit_done) begin
					len_q <= sqrt_res;
					// zero-length edge contributes nothing
					if (sqrt_res == '0)
						for (int i = 0; i < LANES; i++)
							v_q[i] <= '0;
				end
			lsng_pkg::S_SC:
				if (unit_done) v_q[vidx] <= div_res;
			lsng_pkg::S_ACC:
				if (unit_done) c_q[ci] <= lsng_pkg::sadd(c_q[ci], mul_res);
			lsng_pkg::S_Q2:
				if (unit_done) q2_q <= lsng_pkg::ssub(v_q[1], mul_res);
			lsng_pkg::S_Q3:
				if (unit_done)
					q3_q <= lsng_pkg::ssub((j_q == 3'd0) ? v_q[2] : q3_q, mul_res);
			lsng_pkg::S_WGT:
				if (unit_done) begin
					unique case (j_q)
						3'd0:    wz_q <= ures;
						3'd1:    t_q  <= lsng_pkg::ssub(q2_q, ures);
						3'd2:    wy_q <= ures;
						3'd3:    t_q  <= lsng_pkg::ssub(v_q[0], ures);
						3'd4:    t_q  <= lsng_pkg::ssub(t_q, ures);
						default: wx_q <= ures;
					endcase
				end
			lsng_pkg::S_GRD:
				if (unit_done)
					g_q[f_q[FIW-1:0]][a_q] <= lsng_pkg::sadd(g_q[f_q[FIW-1:0]][a_q], mul_res);
			lsng_pkg::S_DIVS:
				if (unit_done) begin
					if (pass_q != lsng_pkg::PASS_R1)
						c23_q <= div_res;
					else if (j_q == 3'd0)
						c12_q <= div_res;
					else
						c13_q <= div_res;
				end
			lsng_pkg::S_EMIT:
				if (emit_ld) begin
					fidx_q <= f_q;
					gx_q   <= degen_q ? '0 : lsng_pkg::clamp48(g_q[f_q[FIW-1:0]][0]);
					gy_q   <= degen_q ? '0 : lsng_pkg::clamp48(g_q[f_q[FIW-1:0]][1]);
					gz_q   <= degen_q ? '0 : lsng_pkg::clamp48(g_q[f_q[FIW-1:0]][2]);
					dg_q   <= degen_q;
					lr_q   <= last_f;
				end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign func_index  = fidx_q;
	assign grad_x      = gx_q;
	assign grad_y      = gy_q;
	assign grad_z      = gz_q;
	assign degenerate  = dg_q;
	assign last_result = lr_q;

endmodule

[sim/testbench.sv]
module testbench;

	typedef logic signed [63:0] q_t;

	// one neighbor word as it goes into the block
	typedef struct packed {
		logic signed [31:0]       ox;
		logic signed [31:0]       oy;
		logic signed [31:0]       oz;
		logic [4:0][31:0]         d;
		logic                     last;
	} nbr_t;

	// one gradient word as it should come out
	typedef struct packed {
		logic [2:0]          fidx;
		logic signed [47:0]  gx;
		logic signed [47:0]  gy;
		logic signed [47:0]  gz;
		logic                degen;
		logic                lastr;
	} grad_t;

	localparam int NBR_MAX = lsng_pkg::MAX_NEIGHBORS_DEF;
	localparam int NFUNC   = lsng_pkg::NUM_FUNCS_DEF;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we, cfg_wdata;
	logic in_valid, in_ready;
	logic signed [31:0] offset_x, offset_y, offset_z;
	logic signed [31:0] diff_0, diff_1, diff_2, diff_3, diff_4;
	logic last_neighbor;
	logic out_valid, out_ready;
	logic [2:0] func_index;
	logic signed [47:0] grad_x, grad_y, grad_z;
	logic degenerate, last_result;

	always #6 clk = ~clk;

	least_squares_node_gradient DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.offset_x(offset_x), .offset_y(offset_y), .offset_z(offset_z),
		.diff_0(diff_0), .diff_1(diff_1), .diff_2(diff_2), .diff_3(diff_3), .diff_4(diff_4),
		.last_neighbor(last_neighbor),
		.out_valid(out_valid), .out_ready(out_ready),
		.func_index(func_index), .grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z),
		.degenerate(degenerate), .last_result(last_result)
	);

	// ---------------------------------------------------------------
	// Predictor state: gathered neighbors of the open node, the mode
	// register copy, and the gradients still owed by the block.
	// ---------------------------------------------------------------
	q_t    nb_ox [NBR_MAX];
	q_t    nb_oy [NBR_MAX];
	q_t    nb_oz [NBR_MAX];
	q_t    nb_df [NBR_MAX*NFUNC];
	int    gather_count = 0;
	logic  wmode = 1'b0;
	grad_t grad_expect[$];

	int    errors = 0;
	bit    steady = 0;     // no random gaps on either side while set
	int    hold_req = 0;   // receiver hold-off, in cycles

	function automatic logic [63:0] magn(input q_t x);
		return x[63] ? 64'(-x) : 64'(x);
	endfunction

	// symmetric saturation to +-(2^63-1)
	function automatic q_t clip_sign(input logic neg, input logic [63:0] m);
		if (m > 64'h7FFF_FFFF_FFFF_FFFF)
			m = 64'h7FFF_FFFF_FFFF_FFFF;
		return neg ? -q_t'(m) : q_t'(m);
	endfunction

	function automatic q_t add_sat(input q_t a, input q_t b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF)
			return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (s < -65'sh0_7FFF_FFFF_FFFF_FFFF)
			return -64'sh7FFF_FFFF_FFFF_FFFF;
		return s[63:0];
	endfunction

	function automatic q_t sub_sat(input q_t a, input q_t b);
		return add_sat(a, -b);
	endfunction

	// (a*b) >> k on magnitudes, truncated
	function automatic q_t mul_shift(input q_t a, input q_t b, input int k);
		logic [127:0] p;
		p = {64'd0, magn(a)} * {64'd0, magn(b)};
		p = p >> k;
		return clip_sign(a[63] ^ b[63], (p[127:64] != 0) ? '1 : p[63:0]);
	endfunction

	// (a << k) / b on magnitudes, truncated; zero divisor gives zero
	function automatic q_t div_shift(input q_t a, input q_t b, input int k);
		logic [127:0] num, quo;
		logic [63:0] dv;
		dv = magn(b);
		if (dv == 0)
			return 0;
		num = {64'd0, magn(a)} << k;
		if (num[127:64] >= dv)
			return clip_sign(a[63] ^ b[63], '1);
		quo = num / {64'd0, dv};
		return clip_sign(a[63] ^ b[63], quo[63:0]);
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'h4000_0000_0000_0000;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic [47:0] clip48(input q_t v);
		if (v > 64'sh0000_7FFF_FFFF_FFFF)
			return 48'h7FFF_FFFF_FFFF;
		if (v < -64'sh0000_8000_0000_0000)
			return 48'h8000_0000_0000;
		return v[47:0];
	endfunction

	// row n scaled by the mode: raw offsets, or offsets over edge length
	function automatic void scale_row(input int n, output q_t s0, output q_t s1,
			output q_t s2, output q_t len);
		logic [63:0] d2;
		q_t l;
		if (!wmode) begin
			s0 = nb_ox[n];
			s1 = nb_oy[n];
			s2 = nb_oz[n];
			len = 65536;
			return;
		end
		d2 = magn(nb_ox[n]) * magn(nb_ox[n]) + magn(nb_oy[n]) * magn(nb_oy[n])
			+ magn(nb_oz[n]) * magn(nb_oz[n]);
		l = q_t'(int_sqrt(d2));
		len = l;
		s0 = (l != 0) ? div_shift(nb_ox[n], l, 16) : 0;
		s1 = (l != 0) ? div_shift(nb_oy[n], l, 16) : 0;
		s2 = (l != 0) ? div_shift(nb_oz[n], l, 16) : 0;
	endfunction

	// Gram-Schmidt solve over the gathered rows, then queue NFUNC gradients
	function automatic void predict_gradients(input int cnt);
		q_t c [lsng_pkg::NUM_COEF];
		q_t g [NFUNC*3];
		q_t s0, s1, s2, len, c12, c13, c23, q2, q3, wx, wy, wz, t, e;
		logic degen;
		grad_t r;
		int n, f;
		foreach (c[i]) c[i] = 0;
		foreach (g[i]) g[i] = 0;
		degen = 1'b0;
		for (n = 0; n < cnt; n++) begin
			scale_row(n, s0, s1, s2, len);
			c[lsng_pkg::C_R11] = add_sat(c[lsng_pkg::C_R11], mul_shift(s0, s0, 0));
			c[lsng_pkg::C_R12] = add_sat(c[lsng_pkg::C_R12], mul_shift(s0, s1, 0));
			c[lsng_pkg::C_R13] = add_sat(c[lsng_pkg::C_R13], mul_shift(s0, s2, 0));
		end
		if (c[lsng_pkg::C_R11] == 0)
			degen = 1'b1;
		if (!degen) begin
			c12 = div_shift(c[lsng_pkg::C_R12], c[lsng_pkg::C_R11], 32);
			c13 = div_shift(c[lsng_pkg::C_R13], c[lsng_pkg::C_R11], 32);
			for (n = 0; n < cnt; n++) begin
				scale_row(n, s0, s1, s2, len);
				q2 = sub_sat(s1, mul_shift(c12, s0, 32));
				c[lsng_pkg::C_R22]  = add_sat(c[lsng_pkg::C_R22],  mul_shift(q2, q2, 0));
				c[lsng_pkg::C_R23]  = add_sat(c[lsng_pkg::C_R23],  mul_shift(q2, s2, 0));
				c[lsng_pkg::C_RO22] = add_sat(c[lsng_pkg::C_RO22], mul_shift(q2, s1, 0));
			end
			if (c[lsng_pkg::C_R22] == 0 || c[lsng_pkg::C_RO22] == 0)
				degen = 1'b1;
		end
		if (!degen) begin
			c23 = div_shift(c[lsng_pkg::C_R23], c[lsng_pkg::C_R22], 32);
			for (n = 0; n < cnt; n++) begin
				scale_row(n, s0, s1, s2, len);
				q2 = sub_sat(s1, mul_shift(c12, s0, 32));
				q3 = sub_sat(sub_sat(s2, mul_shift(c13, s0, 32)), mul_shift(c23, q2, 32));
				c[lsng_pkg::C_R33]  = add_sat(c[lsng_pkg::C_R33],  mul_shift(q3, q3, 0));
				c[lsng_pkg::C_RO33] = add_sat(c[lsng_pkg::C_RO33], mul_shift(q3, s2, 0));
			end
			if (c[lsng_pkg::C_RO33] == 0)
				degen = 1'b1;
		end
		if (!degen) begin
			for (n = 0; n < cnt; n++) begin
				scale_row(n, s0, s1, s2, len);
				q2 = sub_sat(s1, mul_shift(c12, s0, 32));
				q3 = sub_sat(sub_sat(s2, mul_shift(c13, s0, 32)), mul_shift(c23, q2, 32));
				wz = div_shift(q3, c[lsng_pkg::C_RO33], 48);
				t  = sub_sat(q2, mul_shift(c[lsng_pkg::C_R23], wz, 48));
				wy = div_shift(t, c[lsng_pkg::C_RO22], 48);
				t  = sub_sat(sub_sat(s0, mul_shift(c[lsng_pkg::C_R12], wy, 48)),
					mul_shift(c[lsng_pkg::C_R13], wz, 48));
				wx = div_shift(t, c[lsng_pkg::C_R11], 48);
				for (f = 0; f < NFUNC; f++) begin
					e = (len != 0) ? div_shift(nb_df[n*NFUNC + f], len, 16) : 0;
					g[f*3]     = add_sat(g[f*3],     mul_shift(wx, e, 32));
					g[f*3 + 1] = add_sat(g[f*3 + 1], mul_shift(wy, e, 32));
					g[f*3 + 2] = add_sat(g[f*3 + 2], mul_shift(wz, e, 32));
				end
			end
		end
		for (f = 0; f < NFUNC; f++) begin
			r.fidx  = 3'(f);
			r.gx    = degen ? '0 : clip48(g[f*3]);
			r.gy    = degen ? '0 : clip48(g[f*3 + 1]);
			r.gz    = degen ? '0 : clip48(g[f*3 + 2]);
			r.degen = degen;
			r.lastr = (f == NFUNC - 1);
			grad_expect.push_back(r);
		end
	endfunction

	// accepted neighbor word: store it (if room), solve on the last one
	function automatic void take_neighbor(input nbr_t w);
		int f;
		if (gather_count < NBR_MAX) begin
			nb_ox[gather_count] = w.ox;
			nb_oy[gather_count] = w.oy;
			nb_oz[gather_count] = w.oz;
			for (f = 0; f < NFUNC; f++)
				nb_df[gather_count*NFUNC + f] = q_t'($signed(w.d[f]));
			gather_count++;
		end
		if (w.last) begin
			predict_gradients(gather_count);
			gather_count = 0;
		end
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int sel;
		if (steady)
			return 0;
		sel = $urandom_range(0, 19);
		if (sel < 12) return 0;
		if (sel < 18) return $urandom_range(1, 3);
		if (sel < 19) return $urandom_range(5, 15);
		return $urandom_range(30, 80);
	endfunction

	// field value: extremes, zero, full range or moderate Q16.16
	function automatic logic [31:0] pick_field();
		case ($urandom_range(0, 11))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0;
			3, 4: return $urandom;
			default: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
		endcase
	endfunction

	function automatic nbr_t mk(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input logic [31:0] dv, input logic lst);
		nbr_t w;
		w.ox = x; w.oy = y; w.oz = z; w.last = lst;
		for (int f = 0; f < 5; f++)
			w.d[f] = dv ^ (32'(f) << 20);
		return w;
	endfunction

	function automatic nbr_t rand_word(input logic lst);
		nbr_t w;
		w.ox = pick_field(); w.oy = pick_field(); w.oz = pick_field();
		for (int f = 0; f < 5; f++)
			w.d[f] = pick_field();
		w.last = lst;
		return w;
	endfunction

	// ---------------------------------------------------------------
	// Driving. Every task is entered and left right after a rising
	// edge; handshakes are sampled on the falling edge, where the
	// block's ready and valid are settled.
	// ---------------------------------------------------------------
	task automatic send_word(input nbr_t w);
		logic took;
		int gap;
		offset_x <= w.ox; offset_y <= w.oy; offset_z <= w.oz;
		diff_0 <= w.d[0]; diff_1 <= w.d[1]; diff_2 <= w.d[2];
		diff_3 <= w.d[3]; diff_4 <= w.d[4];
		last_neighbor <= w.last;
		in_valid <= 1'b1;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		take_neighbor(w);
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_rand_node(input int cnt);
		for (int i = 0; i < cnt; i++)
			send_word(rand_word(i == cnt - 1));
	endtask

	// sender stops until every owed gradient is in, then lets the block settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (grad_expect.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_mode(input logic m);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we <= 1'b0;
		wmode = m;
	endtask

	// receiver: random stalls, or a long hold-off when asked
	initial begin
		int stall;
		stall = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req > 0) begin
				out_ready <= 1'b0;
				hold_req--;
			end else if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	// gradient checker: every word taken is compared with the oldest owed one
	initial begin
		grad_t x;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (grad_expect.size() == 0) begin
					$error("gradient word with none expected, func_index %0d", func_index);
					errors++;
				end else begin
					x = grad_expect.pop_front();
					if (func_index !== x.fidx) begin
						$error("func_index: expected %0d, got %0d", x.fidx, func_index);
						errors++;
					end
					if (grad_x !== x.gx) begin
						$error("grad_x: expected %0d, got %0d", x.gx, grad_x);
						errors++;
					end
					if (grad_y !== x.gy) begin
						$error("grad_y: expected %0d, got %0d", x.gy, grad_y);
						errors++;
					end
					if (grad_z !== x.gz) begin
						$error("grad_z: expected %0d, got %0d", x.gz, grad_z);
						errors++;
					end
					if (degenerate !== x.degen) begin
						$error("degenerate: expected %0d, got %0d", x.degen, degenerate);
						errors++;
					end
					if (last_result !== x.lastr) begin
						$error("last_result: expected %0d, got %0d", x.lastr, last_result);
						errors++;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// full-scale offsets and differences; saturation paths in both modes
	task automatic test_extremes(input logic m);
		set_mode(m);
		send_word(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0));
		send_word(mk(32'h8000_0000, 32'h0, 32'h0, 32'h8000_0000, 1'b0));
		send_word(mk(32'h0, 32'h8000_0000, 32'h0, 32'h0, 1'b0));
		send_word(mk(32'h0, 32'h0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1));
	endtask

	// zero pivots: lone neighbor, all-zero offsets, points on a line, in a plane
	task automatic test_degenerate();
		set_mode(1'b0);
		send_word(mk(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 1'b1));
		send_word(mk(32'h0, 32'h0, 32'h0, 32'h0005_0000, 1'b0));
		send_word(mk(32'h0, 32'h0, 32'h0, 32'h0006_0000, 1'b0));
		send_word(mk(32'h0, 32'h0, 32'h0, 32'h0007_0000, 1'b1));
		send_word(mk(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b0));
		send_word(mk(32'hFFFE_0000, 32'h0, 32'h0, 32'h0002_0000, 1'b0));
		send_word(mk(32'h0003_8000, 32'h0, 32'h0, 32'hFFFF_0000, 1'b1));
		send_word(mk(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b0));
		send_word(mk(32'h0, 32'h0001_0000, 32'h0, 32'h0002_0000, 1'b0));
		send_word(mk(32'h0002_0000, 32'hFFFF_0000, 32'h0, 32'h0003_0000, 1'b1));
	endtask

	// weighted mode with a zero-length edge among good ones
	task automatic test_zero_edge();
		set_mode(1'b1);
		send_word(mk(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000, 1'b0));
		send_word(mk(32'h0, 32'h0, 32'h0, 32'h7FFF_0000, 1'b0));
		send_word(mk(32'h0, 32'h0002_0000, 32'h0, 32'h0002_0000, 1'b0));
		send_word(mk(32'h0, 32'h0, 32'hFFFF_0000, 32'h0003_0000, 1'b1));
	endtask

	// node sizes mostly 3..8, now and then 1..2
	task automatic test_random(input logic m, input int words);
		int left, cnt;
		set_mode(m);
		left = words;
		while (left > 0) begin
			cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
			if (cnt > left)
				cnt = left;
			send_rand_node(cnt);
			left -= cnt;
		end
	endtask

	// more neighbors than the store holds; the dropped last word still solves
	task automatic test_too_many();
		set_mode(1'b0);
		send_rand_node(NBR_MAX + 2);
	endtask

	// receiver holds off while three nodes go in back to back: the result
	// register fills, the solve stalls, and in_ready must drop
	task automatic test_backpressure();
		set_mode(1'b0);
		hold_req = 8000;
		steady = 1;
		repeat (3) send_rand_node(4);
		steady = 0;
		wait_idle();
	endtask

	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		in_valid <= 1'b0;
		offset_x <= '0; offset_y <= '0; offset_z <= '0;
		diff_0 <= '0; diff_1 <= '0; diff_2 <= '0; diff_3 <= '0; diff_4 <= '0;
		last_neighbor <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_extremes(1'b0);
		test_degenerate();
		test_zero_edge();
		test_extremes(1'b1);
		test_random(1'b0, 80);
		test_random(1'b1, 60);
		test_too_many();
		test_backpressure();
		steady = 1;
		test_random(1'b1, 15);
		steady = 0;
		test_random(1'b0, 30);
		test_random(1'b1, 15);

		wait_idle();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// hard stop, well beyond the slowest correct run
	initial begin
		#30000000;
		$display("simulation failed");
		$finish;
	end

endmodule
